FILE: hdl/upd_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and the hex digit helper for the percent decoder.
// No dependencies; every other file of the block refers to this package by scoped names.
package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // command queue between front and back end
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } upd_out_t;

  // one or two result bytes; the second one always closes the string
  typedef struct packed {
    logic       pair;
    logic [7:0] first_byte;
    logic       first_last;
    logic [7:0] second_byte;
  } upd_cmd_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_PCT    = 2'd1,
    PH_DIGIT  = 2'd2
  } upd_phase_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] plus_to_space(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

FILE: hdl/upd_front.sv
`timescale 1ns / 1ps
// Front end: accepts raw bytes, tracks the escape phase and turns each plain byte or completed escape into a command.
// Depends on upd_pkg.
module upd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  upd_pkg::upd_in_t in_data,
  output logic             cmd_push,
  output upd_pkg::upd_cmd_t cmd
);

  upd_pkg::upd_phase_t phase_r, phase_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                emit;
  logic [4:0]          hi, lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_NORMAL;
      held_r  <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  always_comb begin
    hi        = upd_pkg::hex_digit(held_r);
    lo        = upd_pkg::hex_digit(in_data.in_byte);
    phase_nxt = phase_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    cmd       = '0;
    case (phase_r)
      upd_pkg::PH_PCT: begin
        if (in_data.in_last) begin
          // string ends on the byte after the percent sign: flush both, the second with plus as space
          emit            = 1'b1;
          cmd.pair        = 1'b1;
          cmd.first_byte  = upd_pkg::CHAR_PERCENT;
          cmd.first_last  = 1'b0;
          cmd.second_byte = upd_pkg::plus_to_space(in_data.in_byte);
          phase_nxt       = upd_pkg::PH_NORMAL;
        end else begin
          held_nxt  = in_data.in_byte;
          phase_nxt = upd_pkg::PH_DIGIT;
        end
      end
      upd_pkg::PH_DIGIT: begin
        emit           = 1'b1;
        cmd.first_last = in_data.in_last;
        if (!hi[4]) begin
          cmd.first_byte = 8'h00;
        end else if (!lo[4]) begin
          cmd.first_byte = {4'h0, hi[3:0]};
        end else begin
          cmd.first_byte = {hi[3:0], lo[3:0]};
        end
        phase_nxt = upd_pkg::PH_NORMAL;
      end
      default: begin
        phase_nxt = upd_pkg::PH_NORMAL;
        if (in_data.in_byte == upd_pkg::CHAR_PERCENT && !in_data.in_last) begin
          phase_nxt = upd_pkg::PH_PCT;
        end else begin
          emit           = 1'b1;
          cmd.first_byte = upd_pkg::plus_to_space(in_data.in_byte);
          cmd.first_last = in_data.in_last;
        end
      end
    endcase
    // hold state unless a byte is taken
    if (!accept) begin
      phase_nxt = phase_r;
      held_nxt  = held_r;
    end
  end

  assign cmd_push = accept & emit;

endmodule

FILE: hdl/upd_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the output side.
// Depends on upd_pkg for the command type and depth.
module upd_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output upd_pkg::upd_cmd_t pop_cmd,
  output logic              empty
);

  upd_pkg::upd_cmd_t             slot_r [upd_pkg::CMD_DEPTH];
  logic [upd_pkg::CMD_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [upd_pkg::CMD_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [upd_pkg::CMD_AW:0]      count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full    = (count_r == (upd_pkg::CMD_AW+1)'(upd_pkg::CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == upd_pkg::CMD_AW'(upd_pkg::CMD_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == upd_pkg::CMD_AW'(upd_pkg::CMD_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/upd_back.sv
`timescale 1ns / 1ps
// Back end: drains commands, splits two-byte flushes and holds the output register.
// Depends on upd_pkg.
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  upd_pkg::upd_cmd_t cmd,
  output logic              cmd_pop,
  output upd_pkg::upd_out_t out_data,
  output logic              out_empty,
  input  logic              out_pop
);

  logic              out_valid_r, out_valid_nxt;
  upd_pkg::upd_out_t out_r, out_nxt;
  logic              sec_valid_r, sec_valid_nxt;
  logic [7:0]        sec_byte_r, sec_byte_nxt;
  logic              slot_free;

  assign slot_free = ~out_valid_r | out_pop;
  assign cmd_pop   = slot_free & ~sec_valid_r & ~cmd_empty;
  assign out_data  = out_r;
  assign out_empty = ~out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    sec_valid_nxt = sec_valid_r;
    sec_byte_nxt  = sec_byte_r;
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (sec_valid_r) begin
        // second byte of a flush closes the string
        out_valid_nxt    = 1'b1;
        out_nxt.out_byte = sec_byte_r;
        out_nxt.out_last = 1'b1;
        sec_valid_nxt    = 1'b0;
      end else if (!cmd_empty) begin
        out_valid_nxt    = 1'b1;
        out_nxt.out_byte = cmd.first_byte;
        out_nxt.out_last = cmd.first_last;
        sec_valid_nxt    = cmd.pair;
        sec_byte_nxt     = cmd.second_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    sec_byte_r <= sec_byte_nxt;
  end

endmodule

FILE: hdl/url_percent_decoder.sv
`timescale 1ns / 1ps
// Form-urlencoded percent decoder: one encoded byte in per clock, decoded bytes out through a
// queue-style port. A plus sign becomes a space and a percent sign with two following bytes
// becomes one byte of their hex value, or of the first digit if only the second is no hex digit
// (zero if the first is none); a percent sign near the end of a string passes through. The block
// takes one byte every cycle while its two-entry command queue has room; a decoded byte goes
// through the command queue and then the output register. A percent sign followed by the final
// byte gives two results, which the single output register shows one after the other, so such
// a flush holds the command queue until the second is shown. No clearing pass after reset.
// Depends on upd_pkg, upd_front, upd_cmd_fifo and upd_back.
module url_percent_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  upd_pkg::upd_in_t  in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output upd_pkg::upd_out_t out_data
);

  logic              accept;
  logic              cmd_push, cmd_pop, cmd_empty;
  upd_pkg::upd_cmd_t front_cmd, back_cmd;

  assign accept = in_push & ~in_full;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  upd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .full     (in_full),
    .pop      (cmd_pop),
    .pop_cmd  (back_cmd),
    .empty    (cmd_empty)
  );

  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

FILE: hdl/upd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the percent decoder, attached to the top level by bind.
// Depends on upd_pkg and url_percent_decoder.
module upd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input upd_pkg::upd_out_t out_data
);

  logic acc;
  assign acc = in_push & ~in_full;

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed or vanished while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present right after reset");

  a_rst_room: assert property (@(posedge clk)
    !rst_n |=> !in_full)
    else $error("input blocked right after reset");

  // with nothing pending and no request taken, no result may appear
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && $past(out_empty) && $past(rst_n) && !$past(acc) && !acc) |=> out_empty)
    else $error("result appeared without a request");

endmodule

bind url_percent_decoder upd_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

FILE: tb/tb_url_percent_decoder.sv
`timescale 1ns / 1ps
// Self-checking bench for url_percent_decoder: directed and random encoded strings, random
// push and pop gaps, and a predictor that decodes each request into expected output bytes.
// Depends on upd_pkg and the url_percent_decoder RTL.
module tb_url_percent_decoder;

  typedef struct {
    upd_pkg::upd_in_t req;
    bit               drain;
  } pending_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  upd_pkg::upd_in_t  in_data = '0;
  logic              in_full;
  logic              out_empty;
  logic              out_pop = 1'b0;
  upd_pkg::upd_out_t out_data;

  pending_t            send_q[$];
  upd_pkg::upd_out_t   decoded_q[$];
  upd_pkg::upd_phase_t esc_phase;
  logic [7:0]          esc_digit;
  int                  taken_cnt = 0;
  int                  popped_cnt = 0;
  int                  total_cnt = 0;
  int                  err_cnt = 0;
  int                  push_gap = 0;
  int                  pop_gap = 0;

  url_percent_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("** url_percent_decoder: FAILED **");
    $finish;
  end

  // -1 when the byte is no hex digit
  function automatic int nibble_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] space_for_plus(input logic [7:0] c);
    return (c == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : c;
  endfunction

  task automatic expect_byte(input logic [7:0] b, input logic last);
    upd_pkg::upd_out_t r;
    r.out_byte = b;
    r.out_last = last;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic decode_request(input upd_pkg::upd_in_t r);
    int hi;
    int lo;
    if (esc_phase == upd_pkg::PH_PCT) begin
      if (r.in_last) begin
        expect_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        expect_byte(space_for_plus(r.in_byte), 1'b1);
        esc_phase = upd_pkg::PH_NORMAL;
      end else begin
        esc_digit = r.in_byte;
        esc_phase = upd_pkg::PH_DIGIT;
      end
    end else if (esc_phase == upd_pkg::PH_DIGIT) begin
      hi = nibble_of(esc_digit);
      lo = nibble_of(r.in_byte);
      if (hi < 0) expect_byte(8'h00, r.in_last);
      else if (lo < 0) expect_byte(8'(hi), r.in_last);
      else expect_byte(8'(hi * 16 + lo), r.in_last);
      esc_phase = upd_pkg::PH_NORMAL;
    end else begin
      esc_phase = upd_pkg::PH_NORMAL;
      if (r.in_byte == upd_pkg::CHAR_PERCENT && !r.in_last) esc_phase = upd_pkg::PH_PCT;
      else expect_byte(space_for_plus(r.in_byte), r.in_last);
    end
  endtask

  // bursts without gaps come from the caller; otherwise mostly short gaps, a few long
  function automatic int draw_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  task automatic queue_string(input logic [7:0] s[$], input bit drain);
    pending_t p;
    for (int i = 0; i < s.size(); i++) begin
      p.req.in_byte = s[i];
      p.req.in_last = (i == s.size() - 1);
      p.drain = drain && (i == 0);
      send_q.insert(send_q.size(), p);
    end
    total_cnt += s.size();
  endtask

  task automatic queue_text(input string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.insert(s.size(), t[i]);
    queue_string(s, 1'b0);
  endtask

  // driver: hold the request while full, otherwise load the next one after its gap
  always @(posedge clk) begin
    pending_t p;
    if (!rst_n) begin
      in_push <= 1'b0;
      esc_phase = upd_pkg::PH_NORMAL;
      esc_digit = 8'h00;
    end else begin
      if (in_push && !in_full) begin
        decode_request(in_data);
        taken_cnt++;
        push_gap = draw_gap((taken_cnt % 256) < 48);
      end
      if (!(in_push && in_full)) begin
        if (push_gap > 0) begin
          push_gap--;
          in_push <= 1'b0;
        end else if (send_q.size() == 0) begin
          in_push <= 1'b0;
        end else if (send_q[0].drain && (decoded_q.size() != 0 || in_push)) begin
          in_push <= 1'b0;
        end else begin
          p = send_q.pop_front();
          in_push <= 1'b1;
          in_data <= p.req;
        end
      end
    end
  end

  // monitor: check each popped result against the oldest expected byte
  always @(posedge clk) begin
    upd_pkg::upd_out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        popped_cnt++;
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result byte=%02h last=%0b", $time,
                   out_data.out_byte, out_data.out_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            err_cnt++;
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, out_data.out_byte);
          end
          if (out_data.out_last !== want.out_last) begin
            err_cnt++;
            $display("%0t: out_last expected %0b actual %0b", $time,
                     want.out_last, out_data.out_last);
          end
        end
        pop_gap = draw_gap((popped_cnt % 256) < 48);
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] s[$];
    int         len;
    int         sel;
    int         n_str;
    int         n_dig;

    queue_text("a+b");
    queue_text("%41");
    queue_text("%4g");
    queue_text("%zF");
    queue_text("%fA");
    queue_text("%");
    queue_text("%+");
    queue_text("%%1");
    queue_text("%%");
    s = '{8'h00};
    queue_string(s, 1'b0);
    s = '{8'hFF};
    queue_string(s, 1'b0);

    n_str = 0;
    while (total_cnt < 1525) begin
      s.delete();
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      while (s.size() < len) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          // escape, sometimes cut short to break the sequence
          s.insert(s.size(), upd_pkg::CHAR_PERCENT);
          n_dig = ($urandom_range(0, 99) < 85) ? 2 : $urandom_range(0, 1);
          for (int i = 0; i < n_dig; i++) begin
            s.insert(s.size(), ($urandom_range(0, 9) < 7) ? rand_hex_char() : 8'($urandom));
          end
        end else if (sel < 45) begin
          s.insert(s.size(), upd_pkg::CHAR_PLUS);
        end else if (sel < 50) begin
          s.insert(s.size(), upd_pkg::CHAR_PERCENT);
        end else if (sel < 65) begin
          s.insert(s.size(), rand_hex_char());
        end else begin
          s.insert(s.size(), 8'($urandom));
        end
      end
      queue_string(s, (n_str % 40) == 0);
      n_str++;
    end

    while (taken_cnt < total_cnt || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** url_percent_decoder: PASSED **");
    end else begin
      $display("** url_percent_decoder: FAILED **");
    end
    $finish;
  end

endmodule
